// ===== design/kphp_pkg.sv =====
`default_nettype none
package kphp_pkg;

  // FNV-1a-64 prime is 2^40 + 0x1B3
  localparam int unsigned FNV_SHIFT = 40;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

  localparam int unsigned HASH_W = 64;
  localparam int unsigned POS_W  = 31;
  localparam logic [15:0] NAME_LIMIT = 16'd32768;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_EMPTY = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_SMALL     = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_BAD_ENTRY = 2'd3;

  localparam logic REG_PASSWORD_HASH = 1'b0;
  localparam logic REG_PACKAGE_SIZE  = 1'b1;

  // control of the shared hash round unit
  typedef struct packed {
    logic              step;
    logic              start;
    logic [HASH_W-1:0] basis;
    logic [7:0]        data;
  } fnv_ctl_t;

endpackage
`default_nettype wire

// ===== design/keyed_package_header_parser_core.sv =====
`default_nettype none
// Keyed package header parser. Package bytes arrive one per beat from byte zero; the
// first four give the entry count, and every later header byte is descrambled with a
// per-chunk FNV-1a-64 key, then decoded into entry records and 16-bit name characters.
// All hashing runs through one FNV round unit (one 64x9 multiply-add per cycle while stepping), and
// the block takes one byte at a time: ready rises again only once the accepted byte
// has been fully handled. The fourth count byte also computes the seed (four rounds),
// the first byte of each 8-byte chunk computes the chunk key (eight rounds), and the
// high byte of a name character computes the name hash (two rounds). A result waiting
// in the output register does not block the next accept; work on that next byte starts
// once the output register is free. Configuration writes are taken in any cycle and
// must be made only while the block is idle.
module keyed_package_header_parser_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [1:0]                    out_error_code,
  output logic [15:0]                   out_name_char,
  output logic [kphp_pkg::POS_W-1:0]    out_data_offset,
  output logic [31:0]                   out_uncompressed_size,
  output logic [14:0]                   out_name_length,
  output logic [kphp_pkg::HASH_W-1:0]   out_name_hash,
  output logic                          out_header_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [kphp_pkg::HASH_W-1:0]   cfg_data
);
  import kphp_pkg::*;

  localparam logic [3:0] PH_COUNT_LAST = 4'd3;
  localparam logic [3:0] PH_HEADER     = 4'd4;
  localparam logic [3:0] PH_NLEN_LO    = 4'd12;
  localparam logic [3:0] PH_NLEN_HI    = 4'd13;
  localparam logic [3:0] PH_CHAR_LO    = 4'd14;
  localparam logic [3:0] PH_CHAR_HI    = 4'd15;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SEED, S_SEED_END, S_KEY, S_KEY_END,
    S_DECODE, S_NAME, S_NAME_END, S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  logic [HASH_W-1:0] pwd_r, pwd_nxt;
  logic [POS_W-1:0]  pkg_r, pkg_nxt;

  logic [3:0]        phase_r, phase_nxt;
  logic [31:0]       entries_r, entries_nxt;
  logic [HASH_W-1:0] seed_r, seed_nxt;
  logic [HASH_W-1:0] key_r, key_nxt;
  logic [POS_W-1:0]  hpos_r, hpos_nxt;
  logic [31:0]       foff_r, foff_nxt;
  logic [31:0]       fsize_r, fsize_nxt;
  logic [14:0]       chars_r, chars_nxt;
  logic [15:0]       nlen_r, nlen_nxt;
  logic [7:0]        clow_r, clow_nxt;
  logic [HASH_W-1:0] nhash_r, nhash_nxt;
  logic              fin_r, fin_nxt;

  logic [7:0]        byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic              end_r, end_nxt;
  logic              res_r, res_nxt;
  logic [7:0]        v_r, v_nxt;
  logic [2:0]        round_r, round_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [1:0]        code_r, code_nxt;
  logic [15:0]       char_r, char_nxt;
  logic [POS_W-1:0]  doff_r, doff_nxt;
  logic [31:0]       usize_r, usize_nxt;
  logic [14:0]       olen_r, olen_nxt;
  logic [HASH_W-1:0] ohash_r, ohash_nxt;
  logic              hdone_r, hdone_nxt;

  fnv_ctl_t          fnv_ctl;
  logic [HASH_W-1:0] fnv_hash;

  logic [31:0]       abs_pos;
  logic [2:0]        lane;
  logic [7:0]        v_dec;
  logic [14:0]       chars_dec;
  logic [31:0]       entries_dec;
  logic [HASH_W-1:0] hpos_wide;
  logic              slot_free;

  kphp_fnv_unit u_fnv (
    .clk  (clk),
    .ctl  (fnv_ctl),
    .hash (fnv_hash)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid_r || out_ready;

  assign abs_pos     = (phase_r < PH_HEADER) ? {28'd0, phase_r} : {1'b0, hpos_r} + 32'd4;
  assign lane        = hpos_r[2:0];
  assign v_dec       = byte_r ^ key_r[{lane, 3'b000} +: 8];
  assign chars_dec   = chars_r - 15'd1;
  assign entries_dec = entries_r - 32'd1;
  assign hpos_wide   = {{(HASH_W-POS_W){1'b0}}, hpos_r};

  // shared round unit operand select
  always_comb begin
    fnv_ctl.step  = 1'b0;
    fnv_ctl.start = (round_r == 3'd0);
    fnv_ctl.basis = pwd_r;
    fnv_ctl.data  = entries_r[{round_r[1:0], 3'b000} +: 8];
    case (state_r)
      S_SEED: begin
        fnv_ctl.step = 1'b1;
      end
      S_KEY: begin
        fnv_ctl.step  = 1'b1;
        fnv_ctl.basis = seed_r;
        fnv_ctl.data  = hpos_wide[{round_r, 3'b000} +: 8];
      end
      S_NAME: begin
        fnv_ctl.step  = 1'b1;
        fnv_ctl.basis = nhash_r;
        fnv_ctl.data  = (round_r == 3'd0) ? clow_r : v_r;
      end
      default: begin
        fnv_ctl.step = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    pwd_nxt     = pwd_r;
    pkg_nxt     = pkg_r;
    phase_nxt   = phase_r;
    entries_nxt = entries_r;
    seed_nxt    = seed_r;
    key_nxt     = key_r;
    hpos_nxt    = hpos_r;
    foff_nxt    = foff_r;
    fsize_nxt   = fsize_r;
    chars_nxt   = chars_r;
    nlen_nxt    = nlen_r;
    clow_nxt    = clow_r;
    nhash_nxt   = nhash_r;
    fin_nxt     = fin_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    end_nxt     = end_r;
    res_nxt     = res_r;
    v_nxt       = v_r;
    round_nxt   = round_r;
    kind_nxt    = kind_r;
    code_nxt    = code_r;
    char_nxt    = char_r;
    doff_nxt    = doff_r;
    usize_nxt   = usize_r;
    olen_nxt    = olen_r;
    ohash_nxt   = ohash_r;
    hdone_nxt   = hdone_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PASSWORD_HASH) begin
        pwd_nxt = cfg_data;
      end else begin
        pkg_nxt = cfg_data[POS_W-1:0];
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_data_byte;
          last_nxt  = in_last_byte;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        // hold until the output register is free
        if (slot_free) begin
          res_nxt   = 1'b0;
          kind_nxt  = KIND_CHAR;
          code_nxt  = ERR_NONE;
          char_nxt  = '0;
          doff_nxt  = '0;
          usize_nxt = '0;
          olen_nxt  = '0;
          ohash_nxt = '0;
          hdone_nxt = 1'b0;
          end_nxt   = last_r || ((abs_pos + 32'd1) >= {1'b0, pkg_r});
          round_nxt = 3'd0;
          state_nxt = S_FINISH;
          if (!fin_r) begin
            if (phase_r == 4'd0 && pkg_r < 31'd4) begin
              res_nxt  = 1'b1;
              kind_nxt = KIND_ERROR;
              code_nxt = ERR_SMALL;
              fin_nxt  = 1'b1;
            end else if (abs_pos >= {1'b0, pkg_r}) begin
              res_nxt  = 1'b1;
              kind_nxt = KIND_ERROR;
              code_nxt = ERR_TRUNCATED;
              fin_nxt  = 1'b1;
            end else if (phase_r < PH_HEADER) begin
              entries_nxt = entries_r | ({24'd0, byte_r} << {phase_r[1:0], 3'b000});
              phase_nxt   = phase_r + 4'd1;
              if (phase_r == PH_COUNT_LAST) begin
                state_nxt = S_SEED;
              end
            end else if (lane == 3'd0) begin
              state_nxt = S_KEY;
            end else begin
              state_nxt = S_DECODE;
            end
          end
        end
      end

      S_SEED: begin
        round_nxt = round_r + 3'd1;
        if (round_r == 3'd3) begin
          round_nxt = 3'd0;
          state_nxt = S_SEED_END;
        end
      end

      S_SEED_END: begin
        seed_nxt = fnv_hash;
        if (entries_r == 32'd0) begin
          res_nxt  = 1'b1;
          kind_nxt = KIND_EMPTY;
          fin_nxt  = 1'b1;
        end
        state_nxt = S_FINISH;
      end

      S_KEY: begin
        round_nxt = round_r + 3'd1;
        if (round_r == 3'd7) begin
          state_nxt = S_KEY_END;
        end
      end

      S_KEY_END: begin
        key_nxt   = fnv_hash;
        state_nxt = S_DECODE;
      end

      S_DECODE: begin
        v_nxt     = v_dec;
        hpos_nxt  = hpos_r + 31'd1;
        state_nxt = S_FINISH;
        if (phase_r[3:2] == 2'b01) begin
          foff_nxt  = foff_r | ({24'd0, v_dec} << {phase_r[1:0], 3'b000});
          phase_nxt = phase_r + 4'd1;
        end else if (phase_r[3:2] == 2'b10) begin
          fsize_nxt = fsize_r | ({24'd0, v_dec} << {phase_r[1:0], 3'b000});
          phase_nxt = phase_r + 4'd1;
        end else begin
          case (phase_r)
            PH_NLEN_LO: begin
              nlen_nxt  = {8'd0, v_dec};
              phase_nxt = PH_NLEN_HI;
            end
            PH_NLEN_HI: begin
              nlen_nxt = {v_dec, nlen_r[7:0]};
              if (foff_r > {1'b0, pkg_r} || {v_dec, nlen_r[7:0]} == 16'd0 ||
                  {v_dec, nlen_r[7:0]} >= NAME_LIMIT) begin
                res_nxt  = 1'b1;
                kind_nxt = KIND_ERROR;
                code_nxt = ERR_BAD_ENTRY;
                fin_nxt  = 1'b1;
              end else begin
                chars_nxt = v_dec[6:0] == 7'd0 && nlen_r[7:0] == 8'd0 ? 15'd0
                          : {v_dec[6:0], nlen_r[7:0]};
                nhash_nxt = pwd_r;
                phase_nxt = PH_CHAR_LO;
              end
            end
            PH_CHAR_LO: begin
              clow_nxt  = v_dec;
              phase_nxt = PH_CHAR_HI;
            end
            default: begin
              round_nxt = 3'd0;
              state_nxt = S_NAME;
            end
          endcase
        end
      end

      S_NAME: begin
        round_nxt = round_r + 3'd1;
        if (round_r == 3'd1) begin
          round_nxt = 3'd0;
          state_nxt = S_NAME_END;
        end
      end

      S_NAME_END: begin
        nhash_nxt = fnv_hash;
        chars_nxt = chars_dec;
        char_nxt  = {v_r, clow_r};
        res_nxt   = 1'b1;
        if (chars_dec != 15'd0) begin
          kind_nxt  = KIND_CHAR;
          phase_nxt = PH_CHAR_LO;
        end else begin
          entries_nxt = entries_dec;
          kind_nxt    = KIND_ENTRY;
          doff_nxt    = foff_r[POS_W-1:0];
          usize_nxt   = fsize_r;
          olen_nxt    = nlen_r[14:0];
          ohash_nxt   = fnv_hash;
          hdone_nxt   = (entries_dec == 32'd0);
          if (entries_dec == 32'd0) begin
            fin_nxt = 1'b1;
          end
          foff_nxt  = '0;
          fsize_nxt = '0;
          nlen_nxt  = '0;
          clow_nxt  = '0;
          phase_nxt = PH_HEADER;
        end
        state_nxt = S_FINISH;
      end

      S_FINISH: begin
        // stream ended, or the package size was reached, with the header incomplete: fail the package
        if (!fin_r && end_r) begin
          kind_nxt  = KIND_ERROR;
          code_nxt  = ERR_TRUNCATED;
          char_nxt  = '0;
          doff_nxt  = '0;
          usize_nxt = '0;
          olen_nxt  = '0;
          ohash_nxt = '0;
          hdone_nxt = 1'b0;
          fin_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
        end else begin
          out_valid_nxt = res_r;
        end
        if (last_r) begin
          phase_nxt   = '0;
          entries_nxt = '0;
          seed_nxt    = '0;
          key_nxt     = '0;
          hpos_nxt    = '0;
          foff_nxt    = '0;
          fsize_nxt   = '0;
          chars_nxt   = '0;
          nlen_nxt    = '0;
          clow_nxt    = '0;
          nhash_nxt   = '0;
          fin_nxt     = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pwd_r       <= '0;
      pkg_r       <= '0;
      phase_r     <= '0;
      entries_r   <= '0;
      seed_r      <= '0;
      key_r       <= '0;
      hpos_r      <= '0;
      foff_r      <= '0;
      fsize_r     <= '0;
      chars_r     <= '0;
      nlen_r      <= '0;
      clow_r      <= '0;
      nhash_r     <= '0;
      fin_r       <= 1'b0;
      res_r       <= 1'b0;
      end_r       <= 1'b0;
      last_r      <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pwd_r       <= pwd_nxt;
      pkg_r       <= pkg_nxt;
      phase_r     <= phase_nxt;
      entries_r   <= entries_nxt;
      seed_r      <= seed_nxt;
      key_r       <= key_nxt;
      hpos_r      <= hpos_nxt;
      foff_r      <= foff_nxt;
      fsize_r     <= fsize_nxt;
      chars_r     <= chars_nxt;
      nlen_r      <= nlen_nxt;
      clow_r      <= clow_nxt;
      nhash_r     <= nhash_nxt;
      fin_r       <= fin_nxt;
      res_r       <= res_nxt;
      end_r       <= end_nxt;
      last_r      <= last_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r  <= byte_nxt;
    v_r     <= v_nxt;
    kind_r  <= kind_nxt;
    code_r  <= code_nxt;
    char_r  <= char_nxt;
    doff_r  <= doff_nxt;
    usize_r <= usize_nxt;
    olen_r  <= olen_nxt;
    ohash_r <= ohash_nxt;
    hdone_r <= hdone_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_kind              = kind_r;
  assign out_error_code        = code_r;
  assign out_name_char         = char_r;
  assign out_data_offset       = doff_r;
  assign out_uncompressed_size = usize_r;
  assign out_name_length       = olen_r;
  assign out_name_hash         = ohash_r;
  assign out_header_done       = hdone_r;

  a_emit_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result raised outside the finish step");

  a_done_only_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && hdone_r) |-> (kind_r == KIND_ENTRY))
    else $error("header done flagged without a completed entry");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_ERROR) |->
      (ohash_r == '0 && char_r == '0 && hdone_r == 1'b0 && code_r != ERR_NONE))
    else $error("error result carries payload");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && last_r) |=> (phase_r == '0 && !fin_r && hpos_r == '0))
    else $error("parse state not re-armed after last beat");

  a_name_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NAME) |-> (phase_r == PH_CHAR_HI && chars_r != '0))
    else $error("name hash rounds outside a character");

endmodule
`default_nettype wire

// ===== design/kphp_fnv_unit.sv =====
`default_nettype none
module kphp_fnv_unit (
  input  logic                      clk,
  input  kphp_pkg::fnv_ctl_t        ctl,
  output logic [kphp_pkg::HASH_W-1:0] hash
);
  import kphp_pkg::*;

  logic [HASH_W-1:0] acc_r;
  logic [HASH_W-1:0] acc_nxt;
  logic [HASH_W-1:0] src;
  logic [HASH_W-1:0] mixed;

  // one FNV-1a round a cycle while step is high; start takes the basis in place of the accumulator
  always_comb begin
    src     = ctl.start ? ctl.basis : acc_r;
    mixed   = src ^ {{(HASH_W-8){1'b0}}, ctl.data};
    acc_nxt = (mixed << FNV_SHIFT) + (mixed * {{(HASH_W-9){1'b0}}, FNV_PRIME_LO});
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      acc_r <= acc_nxt;
    end
  end

  assign hash = acc_r;

endmodule
`default_nettype wire

// ===== bench/tb_keyed_package_header_parser_core.sv =====
`timescale 1ns / 100ps

module tb_keyed_package_header_parser_core;
  import kphp_pkg::*;

  localparam logic [63:0] FNV64_PRIME = (64'd1 << FNV_SHIFT) | 64'(FNV_PRIME_LO);
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_AT = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  err;
    logic [15:0] name_char;
    logic [30:0] data_offset;
    logic [31:0] usize;
    logic [14:0] name_len;
    logic [63:0] name_hash;
    logic        hdr_done;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic        cfg_reg;
    logic [63:0] value;
    bit          last;
    bit          has_exp;
    result_t     exp;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [1:0]  out_error_code;
  logic [15:0] out_name_char;
  logic [30:0] out_data_offset;
  logic [31:0] out_uncompressed_size;
  logic [14:0] out_name_length;
  logic [63:0] out_name_hash;
  logic        out_header_done;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [63:0] cfg_data;

  keyed_package_header_parser_core u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_data_byte          (in_data_byte),
    .in_last_byte          (in_last_byte),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_kind              (out_kind),
    .out_error_code        (out_error_code),
    .out_name_char         (out_name_char),
    .out_data_offset       (out_data_offset),
    .out_uncompressed_size (out_uncompressed_size),
    .out_name_length       (out_name_length),
    .out_name_hash         (out_name_hash),
    .out_header_done       (out_header_done),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // parser shadow: configuration and parse state
  logic [63:0] prs_password;
  logic [30:0] prs_pkg_size;
  logic [3:0]  prs_phase;
  logic [31:0] prs_entries;
  logic [63:0] prs_seed;
  logic [63:0] prs_chunk_key;
  logic [30:0] prs_hdr_pos;
  logic [31:0] prs_offset;
  logic [31:0] prs_usize;
  logic [15:0] prs_chars_left;
  logic [15:0] prs_name_len;
  logic [7:0]  prs_char_lo;
  logic [63:0] prs_name_hash;
  bit          prs_closed;

  // stimulus side: scrambles plain header bytes the way a package writer would
  logic [63:0] scr_pw;
  int unsigned scr_idx;
  logic [31:0] scr_count;
  logic [63:0] scr_seed;
  logic [63:0] scr_key;

  result_t   expected_results[$];
  stim_row_t stim_rows[$];
  result_t   head_rec;
  int        mismatches;
  bit        send_calm;

  function automatic logic [63:0] fnv_bytes(logic [63:0] h, logic [63:0] v, int n);
    for (int i = 0; i < n; i++)
      h = (h ^ {56'd0, v[8*i +: 8]}) * FNV64_PRIME;
    return h;
  endfunction

  function automatic int draw_gap(inout bit calm);
    if ($urandom_range(0, 31) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void rearm_parser();
    prs_phase = 4'd0;
    prs_entries = '0;
    prs_seed = '0;
    prs_chunk_key = '0;
    prs_hdr_pos = '0;
    prs_offset = '0;
    prs_usize = '0;
    prs_chars_left = '0;
    prs_name_len = '0;
    prs_char_lo = '0;
    prs_name_hash = '0;
    prs_closed = 1'b0;
  endfunction

  function automatic bit close_with_error(logic [1:0] code, output result_t r);
    r = '0;
    r.kind = KIND_ERROR;
    r.err = code;
    prs_closed = 1'b1;
    return 1'b1;
  endfunction

  // one descrambled header byte through the entry field decoder
  function automatic bit decode_header_byte(logic [7:0] v, inout result_t r);
    case (prs_phase)
      4'd4, 4'd5, 4'd6, 4'd7: begin
        prs_offset = prs_offset | (32'(v) << (8 * (prs_phase - 4'd4)));
        prs_phase++;
        return 1'b0;
      end
      4'd8, 4'd9, 4'd10, 4'd11: begin
        prs_usize = prs_usize | (32'(v) << (8 * (prs_phase - 4'd8)));
        prs_phase++;
        return 1'b0;
      end
      4'd12: begin
        prs_name_len = {8'd0, v};
        prs_phase = 4'd13;
        return 1'b0;
      end
      4'd13: begin
        prs_name_len = prs_name_len | {v, 8'd0};
        if (prs_offset > {1'b0, prs_pkg_size} || prs_name_len == 16'd0 ||
            prs_name_len >= NAME_LIMIT)
          return close_with_error(ERR_BAD_ENTRY, r);
        prs_chars_left = prs_name_len;
        prs_name_hash = prs_password;
        prs_phase = 4'd14;
        return 1'b0;
      end
      4'd14: begin
        prs_char_lo = v;
        prs_phase = 4'd15;
        return 1'b0;
      end
      default: begin
        prs_name_hash = fnv_bytes(prs_name_hash, {48'd0, v, prs_char_lo}, 2);
        prs_chars_left = prs_chars_left - 16'd1;
        r.name_char = {v, prs_char_lo};
        if (prs_chars_left != 16'd0) begin
          r.kind = KIND_CHAR;
          prs_phase = 4'd14;
          return 1'b1;
        end
        prs_entries = prs_entries - 32'd1;
        r.kind = KIND_ENTRY;
        r.data_offset = prs_offset[30:0];
        r.usize = prs_usize;
        r.name_len = prs_name_len[14:0];
        r.name_hash = prs_name_hash;
        r.hdr_done = (prs_entries == 32'd0);
        if (prs_entries == 32'd0)
          prs_closed = 1'b1;
        prs_offset = '0;
        prs_usize = '0;
        prs_name_len = '0;
        prs_char_lo = '0;
        prs_phase = 4'd4;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic bit decode_package_byte(logic [7:0] b, bit last, output result_t r);
    logic [32:0] abs_pos;
    logic [2:0]  lane;
    bit          got;
    r = '0;
    got = 1'b0;
    if (!prs_closed) begin
      abs_pos = (prs_phase < 4'd4) ? 33'(prs_phase) : 33'(prs_hdr_pos) + 33'd4;
      if (prs_phase == 4'd0 && prs_pkg_size < 31'd4) begin
        got = close_with_error(ERR_SMALL, r);
      end else if (abs_pos >= 33'(prs_pkg_size)) begin
        got = close_with_error(ERR_TRUNCATED, r);
      end else begin
        if (prs_phase < 4'd4) begin
          prs_entries = prs_entries | (32'(b) << (8 * prs_phase));
          prs_phase++;
          if (prs_phase == 4'd4) begin
            prs_seed = fnv_bytes(prs_password, {32'd0, prs_entries}, 4);
            if (prs_entries == 32'd0) begin
              r.kind = KIND_EMPTY;
              prs_closed = 1'b1;
              got = 1'b1;
            end
          end
        end else begin
          lane = prs_hdr_pos[2:0];
          if (lane == 3'd0)
            prs_chunk_key = fnv_bytes(prs_seed, {33'd0, prs_hdr_pos}, 8);
          prs_hdr_pos = prs_hdr_pos + 31'd1;
          got = decode_header_byte(b ^ prs_chunk_key[8*lane +: 8], r);
        end
        // an unfinished header at the end of the stream or of the package size fails the whole package
        if (!prs_closed && (last || abs_pos + 33'd1 >= 33'(prs_pkg_size)))
          got = close_with_error(ERR_TRUNCATED, r);
      end
    end
    if (last)
      rearm_parser();
    return got;
  endfunction

  function automatic logic [7:0] scramble_byte(logic [7:0] plain, bit last);
    logic [7:0]  raw;
    int unsigned hp;
    if (scr_idx < 4) begin
      raw = plain;
      scr_count[8*scr_idx +: 8] = plain;
      if (scr_idx == 3)
        scr_seed = fnv_bytes(scr_pw, {32'd0, scr_count}, 4);
    end else begin
      hp = scr_idx - 4;
      if (hp % 8 == 0)
        scr_key = fnv_bytes(scr_seed, 64'(hp), 8);
      raw = plain ^ scr_key[8*(hp % 8) +: 8];
    end
    scr_idx++;
    if (last) begin
      scr_idx = 0;
      scr_count = '0;
    end
    return raw;
  endfunction

  function automatic void add_cfg(logic idx, logic [63:0] v);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_reg = idx;
    row.value = v;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_byte(logic [7:0] b, bit last);
    stim_row_t row;
    row = '{default: '0};
    row.value = {56'd0, b};
    row.last = last;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [7:0] b, bit last, logic [1:0] k, logic [1:0] e);
    stim_row_t row;
    row = '{default: '0};
    row.value = {56'd0, b};
    row.last = last;
    row.has_exp = 1'b1;
    row.exp.kind = k;
    row.exp.err = e;
    stim_rows.push_back(row);
  endfunction

  // one package in plain form: mostly well formed, some cut short, a few pure noise
  function automatic int plan_package(logic [30:0] size);
    logic [7:0]  body[$];
    int unsigned n_ent;
    int unsigned roll;
    int unsigned pick;
    logic [31:0] off;
    logic [31:0] usz;
    logic [15:0] nlen;
    logic [15:0] ch;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      repeat ($urandom_range(1, 12)) body.push_back(8'($urandom));
    end else begin
      n_ent = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < 4; i++)
        body.push_back(n_ent[8*i +: 8]);
      repeat (n_ent) begin
        pick = $urandom_range(0, 99);
        if (pick < 85)      off = $urandom_range(0, size);
        else if (pick < 90) off = {1'b0, size};
        else if (pick < 95) off = {1'b0, size} + 32'd1;
        else                off = $urandom;
        usz = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 80)      nlen = 16'($urandom_range(1, 4));
        else if (pick < 90) nlen = 16'($urandom_range(5, 16));
        else if (pick < 93) nlen = 16'($urandom_range(40, 80));
        else if (pick < 95) nlen = 16'd0;
        else if (pick < 97) nlen = NAME_LIMIT;
        else if (pick < 98) nlen = 16'hFFFF;
        else                nlen = 16'($urandom_range(32768, 65535));
        for (int i = 0; i < 4; i++) body.push_back(off[8*i +: 8]);
        for (int i = 0; i < 4; i++) body.push_back(usz[8*i +: 8]);
        body.push_back(nlen[7:0]);
        body.push_back(nlen[15:8]);
        if (nlen != 16'd0 && nlen < NAME_LIMIT)
          repeat (nlen) begin
            ch = 16'($urandom);
            body.push_back(ch[7:0]);
            body.push_back(ch[15:8]);
          end
      end
      if (roll >= 85)
        body = body[0:$urandom_range(0, body.size() - 1)];
      else
        repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
    end
    foreach (body[i])
      add_byte(body[i], i == body.size() - 1);
    return body.size();
  endfunction

  function automatic void plan_phase(logic [63:0] pw, logic [30:0] size, int budget);
    int fed;
    fed = 0;
    add_cfg(REG_PASSWORD_HASH, pw);
    add_cfg(REG_PACKAGE_SIZE, {33'd0, size});
    while (fed < budget)
      fed += plan_package(size);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic drain_and_settle();
    in_valid = 1'b0;
    while (expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [63:0] v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PASSWORD_HASH) begin
      prs_password = v;
      scr_pw = v;
    end else begin
      prs_pkg_size = v[30:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic feed_byte(input stim_row_t row);
    int         gap;
    logic [7:0] raw;
    result_t    rec;
    bit         got;
    raw = scramble_byte(row.value[7:0], row.last);
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = raw;
    in_last_byte = row.last;
    do @(posedge clk); while (!in_ready);
    got = decode_package_byte(raw, row.last, rec);
    if (row.has_exp)
      expected_results.push_back(row.exp);
    else if (got)
      expected_results.push_back(rec);
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_PASSWORD_HASH;
    cfg_data = '0;
    mismatches = 0;
    send_calm = 1'b0;
    prs_password = '0;
    prs_pkg_size = '0;
    scr_pw = '0;
    scr_idx = 0;
    scr_count = '0;
    scr_seed = '0;
    scr_key = '0;
    rearm_parser();

    // registers still at reset: any first byte is a too-small package
    add_checked(8'hFF, 1'b1, KIND_ERROR, ERR_SMALL);
    add_cfg(REG_PACKAGE_SIZE, 64'd3);
    add_cfg(REG_PASSWORD_HASH, '1);
    add_checked(8'h00, 1'b0, KIND_ERROR, ERR_SMALL);
    add_byte(8'h80, 1'b1);
    // four-byte package: empty count, then a count with no room for entries
    add_cfg(REG_PACKAGE_SIZE, 64'd4);
    repeat (3) add_byte(8'h00, 1'b0);
    add_checked(8'h00, 1'b0, KIND_EMPTY, ERR_NONE);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h01, 1'b0);
    repeat (2) add_byte(8'h00, 1'b0);
    add_checked(8'h00, 1'b0, KIND_ERROR, ERR_TRUNCATED);
    add_byte(8'h5A, 1'b1);
    // offset equal to the package size passes, name length 32768 does not
    add_cfg(REG_PACKAGE_SIZE, 64'h7FFF_FFFF);
    add_byte(8'h01, 1'b0);
    repeat (3) add_byte(8'h00, 1'b0);
    repeat (3) add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b0);
    repeat (4) add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_checked(8'h80, 1'b1, KIND_ERROR, ERR_BAD_ENTRY);

    plan_phase({$urandom, $urandom}, 31'h7FFF_FFFF, 125);
    plan_phase(64'd0, 31'd1200, 125);
    plan_phase('1, 31'd48, 125);
    plan_phase({$urandom, $urandom}, 31'($urandom_range(16, 3000)), 125);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        drain_and_settle();
        write_register(stim_rows[i].cfg_reg, stim_rows[i].value);
      end else begin
        feed_byte(stim_rows[i]);
      end
    end
    drain_and_settle();

    if (mismatches == 0)
      $display("tb_keyed_package_header_parser_core: PASS");
    else
      $display("tb_keyed_package_header_parser_core: FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off to back the block up
  initial begin
    int gap;
    bit calm;
    int taken;
    calm = 1'b0;
    taken = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = (taken == HOLD_AT) ? HOLD_CYCLES : draw_gap(calm);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, kind", 64'(out_kind), '0);
      end else begin
        head_rec = expected_results.pop_front();
        if (out_kind !== head_rec.kind)
          report_mismatch("kind", 64'(out_kind), 64'(head_rec.kind));
        if (out_error_code !== head_rec.err)
          report_mismatch("error_code", 64'(out_error_code), 64'(head_rec.err));
        if (out_name_char !== head_rec.name_char)
          report_mismatch("name_char", 64'(out_name_char), 64'(head_rec.name_char));
        if (out_data_offset !== head_rec.data_offset)
          report_mismatch("data_offset", 64'(out_data_offset), 64'(head_rec.data_offset));
        if (out_uncompressed_size !== head_rec.usize)
          report_mismatch("uncompressed_size", 64'(out_uncompressed_size),
                          64'(head_rec.usize));
        if (out_name_length !== head_rec.name_len)
          report_mismatch("name_length", 64'(out_name_length), 64'(head_rec.name_len));
        if (out_name_hash !== head_rec.name_hash)
          report_mismatch("name_hash", out_name_hash, head_rec.name_hash);
        if (out_header_done !== head_rec.hdr_done)
          report_mismatch("header_done", 64'(out_header_done), 64'(head_rec.hdr_done));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_keyed_package_header_parser_core: FAIL");
    $finish;
  end

endmodule
